>>> rtl/elgm_pkg.sv
package elgm_pkg;

    // Command carried with each input transaction.
    typedef enum logic [1:0] {
        CMD_CHAR     = 2'd0,
        CMD_END_CODE = 2'd1,
        CMD_END_LIST = 2'd2
    } t_cmd;

    // Parser phase within one location code, one-hot.
    typedef enum logic [4:0] {
        PH_Z    = 5'b00001,
        PH_ZONE = 5'b00010,
        PH_DIG  = 5'b00100,
        PH_SUB  = 5'b01000,
        PH_ERR  = 5'b10000
    } t_phase;

    // Configuration register indexes.
    typedef enum logic {
        CFG_HOME_ZONE   = 1'b0,
        CFG_HOME_DIGITS = 1'b1
    } t_cfg_idx;

    // Per-code status codes.
    typedef enum logic [1:0] {
        ST_INVALID  = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_MATCH    = 2'd2
    } t_status;

    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam int ZONE_W         = 10;
    localparam int ZONE_MAX       = 41;
    localparam int ZONE_CHARS_MAX = 3;
    localparam int SUB_CHARS      = 4;
    localparam int SUB_W          = 16;
    localparam int HOME_ZONE_W    = 6;

    // One result transaction.
    typedef struct packed {
        logic    code_closed;
        t_status code_status;
        logic    list_done;
        logic    relevant;
    } t_result;

    // Hex character decode: bit 4 set when the character is a hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

>>> rtl/elgm_parse.sv
module elgm_parse #(
    parameter int MAX_DIGITS = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  elgm_pkg::t_cmd                     i_cmd,
    input  logic [7:0]                         i_ch,
    input  logic [elgm_pkg::HOME_ZONE_W-1:0]   i_home_zone,
    input  logic [4*MAX_DIGITS-1:0]            i_home_digits,
    output logic                               o_has_result,
    output elgm_pkg::t_result                  o_result
);

    localparam int DC_W = $clog2(MAX_DIGITS + 1);

    elgm_pkg::t_phase              r_phase, n_phase;
    logic [elgm_pkg::ZONE_W-1:0]   r_zone, n_zone;
    logic [1:0]                    r_zchars, n_zchars;
    logic [DC_W-1:0]               r_dcnt, n_dcnt;
    logic                          r_pfx, n_pfx;
    logic [elgm_pkg::SUB_W-1:0]    r_sub, n_sub;
    logic [2:0]                    r_schars, n_schars;
    logic                          r_open, n_open;
    logic                          r_usable, n_usable;
    logic                          r_match, n_match;

    logic [4:0] hex;
    logic [3:0] home_dig;
    logic       code_valid;
    logic       code_hit;
    logic       zone_ok;
    logic       is_dec;

    // Home digit selected by the current digit count.
    always_comb begin
        home_dig = 4'd0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_dcnt == DC_W'(i)) begin
                home_dig = i_home_digits[4*(MAX_DIGITS-1-i) +: 4];
            end
        end
    end

    assign hex    = elgm_pkg::hex_decode(i_ch);
    assign is_dec = (i_ch >= elgm_pkg::CH_0) && (i_ch <= elgm_pkg::CH_9);

    // Verdict of the code collected so far.
    always_comb begin
        code_valid = ((r_phase == elgm_pkg::PH_DIG) && (r_dcnt != '0)) ||
                     ((r_phase == elgm_pkg::PH_SUB) && (r_dcnt != '0) &&
                      (r_schars == 3'(elgm_pkg::SUB_CHARS)));
        zone_ok    = r_zone == {{(elgm_pkg::ZONE_W-elgm_pkg::HOME_ZONE_W){1'b0}},
                                i_home_zone};
        code_hit   = code_valid && zone_ok && r_pfx;
        if ((r_phase == elgm_pkg::PH_SUB) && (r_dcnt < DC_W'(MAX_DIGITS))) begin
            code_hit = code_hit && r_sub[home_dig];
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_zone       = r_zone;
        n_zchars     = r_zchars;
        n_dcnt       = r_dcnt;
        n_pfx        = r_pfx;
        n_sub        = r_sub;
        n_schars     = r_schars;
        n_open       = r_open;
        n_usable     = r_usable;
        n_match      = r_match;
        o_has_result = 1'b0;
        o_result     = '{code_closed: 1'b0, code_status: elgm_pkg::ST_INVALID,
                         list_done: 1'b0, relevant: 1'b0};

        case (i_cmd)
            elgm_pkg::CMD_CHAR: begin
                n_open = 1'b1;
                unique case (r_phase)
                    elgm_pkg::PH_Z: begin
                        n_phase = (i_ch == elgm_pkg::CH_Z) ? elgm_pkg::PH_ZONE
                                                            : elgm_pkg::PH_ERR;
                    end
                    elgm_pkg::PH_ZONE: begin
                        if (i_ch == elgm_pkg::CH_COLON) begin
                            n_phase = ((r_zchars != 2'd0) &&
                                       (r_zone <= elgm_pkg::ZONE_W'(elgm_pkg::ZONE_MAX)))
                                      ? elgm_pkg::PH_DIG : elgm_pkg::PH_ERR;
                        end else if (is_dec &&
                                     (r_zchars < 2'(elgm_pkg::ZONE_CHARS_MAX))) begin
                            n_zone   = (r_zone << 3) + (r_zone << 1) +
                                       elgm_pkg::ZONE_W'(hex[3:0]);
                            n_zchars = r_zchars + 2'd1;
                        end else begin
                            n_phase = elgm_pkg::PH_ERR;
                        end
                    end
                    elgm_pkg::PH_DIG: begin
                        if (i_ch == elgm_pkg::CH_PLUS) begin
                            n_phase = (r_dcnt != '0) ? elgm_pkg::PH_SUB : elgm_pkg::PH_ERR;
                        end else if (hex[4] && (r_dcnt < DC_W'(MAX_DIGITS))) begin
                            if (hex[3:0] != home_dig) begin
                                n_pfx = 1'b0;
                            end
                            n_dcnt = r_dcnt + DC_W'(1);
                        end else begin
                            n_phase = elgm_pkg::PH_ERR;
                        end
                    end
                    elgm_pkg::PH_SUB: begin
                        if (hex[4] && (r_schars < 3'(elgm_pkg::SUB_CHARS))) begin
                            n_sub    = {r_sub[elgm_pkg::SUB_W-5:0], hex[3:0]};
                            n_schars = r_schars + 3'd1;
                        end else begin
                            n_phase = elgm_pkg::PH_ERR;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            elgm_pkg::CMD_END_CODE, elgm_pkg::CMD_END_LIST: begin
                o_has_result = 1'b1;
                if (r_open) begin
                    o_result.code_status = code_hit   ? elgm_pkg::ST_MATCH :
                                           code_valid ? elgm_pkg::ST_NO_MATCH :
                                                        elgm_pkg::ST_INVALID;
                end
                o_result.code_closed = (i_cmd == elgm_pkg::CMD_END_CODE) || r_open;
                n_usable = r_usable || (r_open && code_valid);
                n_match  = r_match || (r_open && code_hit);
                n_phase  = elgm_pkg::PH_Z;
                n_zone   = '0;
                n_zchars = '0;
                n_dcnt   = '0;
                n_pfx    = 1'b1;
                n_sub    = '0;
                n_schars = '0;
                n_open   = 1'b0;
                if (i_cmd == elgm_pkg::CMD_END_LIST) begin
                    o_result.list_done = 1'b1;
                    o_result.relevant  = n_match || !n_usable;
                    n_usable = 1'b0;
                    n_match  = 1'b0;
                end
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= elgm_pkg::PH_Z;
            r_zone   <= '0;
            r_zchars <= '0;
            r_dcnt   <= '0;
            r_pfx    <= 1'b1;
            r_sub    <= '0;
            r_schars <= '0;
            r_open   <= 1'b0;
            r_usable <= 1'b0;
            r_match  <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_zone   <= n_zone;
            r_zchars <= n_zchars;
            r_dcnt   <= n_dcnt;
            r_pfx    <= n_pfx;
            r_sub    <= n_sub;
            r_schars <= n_schars;
            r_open   <= n_open;
            r_usable <= n_usable;
            r_match  <= n_match;
        end
    end

endmodule

>>> rtl/ews_location_code_geofence_match.sv
// EWS location code matcher. Each input transaction carries one character of
// an alert's location code list (cmd 0), an end-of-code mark (cmd 1) or an
// end-of-list mark (cmd 2). Codes look like "Z<zone>:<hex digits>[+<4 hex>]"
// and are checked against the home zone and home digits held in the two
// configuration registers. An end-of-code transaction yields one result with
// the code's status (invalid, valid without match, match); an end-of-list
// transaction yields one result with the list verdict, which is relevant when
// any code matched or no code was valid, and it also closes a code left open.
// Characters and the unused command yield no result. The block takes one
// transaction per clock while the input is not stalled: an input register
// feeds a single pass of parser logic whose state updates on each transaction
// that fires, and a result register holds the outgoing transaction. A result
// is presented after its closing transaction has passed the input register
// and then the result register. Input is stalled only while a result-producing
// transaction waits for a stalled result register. The user must write
// configuration only while the block is idle; the block does not enforce it.
module ews_location_code_geofence_match #(
    parameter int MAX_DIGITS = 6
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // Input channel.
    input  logic                                          i_in_valid,
    output logic                                          o_in_stall,
    input  logic [1:0]                                    i_cmd,
    input  logic [7:0]                                    i_ch,
    // Result channel.
    output logic                                          o_out_valid,
    input  logic                                          i_out_stall,
    output logic                                          o_code_closed,
    output logic [1:0]                                    o_code_status,
    output logic                                          o_list_done,
    output logic                                          o_relevant,
    // Configuration write port.
    input  logic                                          i_cfg_we,
    input  logic                                          i_cfg_index,
    input  logic [((4*MAX_DIGITS > 6) ? 4*MAX_DIGITS : 6)-1:0] i_cfg_wdata
);

    localparam int HD_W = 4 * MAX_DIGITS;

    // Configuration registers.
    logic [elgm_pkg::HOME_ZONE_W-1:0] r_home_zone;
    logic [HD_W-1:0]                  r_home_digits;

    // Input register.
    logic             r_in_vld;
    elgm_pkg::t_cmd   r_cmd;
    logic [7:0]       r_ch;

    // Result register.
    logic              r_out_vld;
    elgm_pkg::t_result r_out;

    logic              in_accept;
    logic              out_free;
    logic              fire;
    logic              has_result;
    elgm_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_zone   <= '0;
            r_home_digits <= '0;
        end else if (i_cfg_we) begin
            unique case (elgm_pkg::t_cfg_idx'(i_cfg_index))
                elgm_pkg::CFG_HOME_ZONE:   r_home_zone   <= i_cfg_wdata[elgm_pkg::HOME_ZONE_W-1:0];
                elgm_pkg::CFG_HOME_DIGITS: r_home_digits <= i_cfg_wdata[HD_W-1:0];
                default:                   r_home_zone   <= r_home_zone;
            endcase
        end
    end

    // The result register can take a new result when it is empty or being
    // drained this cycle. A held item that produces no result never waits.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && (!has_result || out_free);
    assign o_in_stall = r_in_vld && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= elgm_pkg::t_cmd'(i_cmd);
            r_ch  <= i_ch;
        end
    end

    elgm_parse #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_cmd         (r_cmd),
        .i_ch          (r_ch),
        .i_home_zone   (r_home_zone),
        .i_home_digits (r_home_digits),
        .o_has_result  (has_result),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= fire && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && fire && has_result) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_code_closed = r_out.code_closed;
    assign o_code_status = r_out.code_status;
    assign o_list_done   = r_out.list_done;
    assign o_relevant    = r_out.relevant;

endmodule

>>> tb/testbench.sv
// Tracks the location code parser, predicts one result per closing
// transaction and checks the block's results against those predictions.
class geofence_tracker;

    localparam int NUM_DIGITS = 6;
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_F  = "F";
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_LOW_F = "f";

    logic [elgm_pkg::HOME_ZONE_W-1:0] home_zone;
    logic [4*NUM_DIGITS-1:0] home_digits;

    elgm_pkg::t_phase          phase;
    logic [elgm_pkg::ZONE_W-1:0] zone_val;
    logic [2:0]      zone_chars;
    logic [2:0]      digit_count;
    bit              prefix_ok;
    logic [elgm_pkg::SUB_W-1:0] sub_val;
    logic [2:0]      sub_chars;
    bit              code_open;
    bit              any_usable;
    bit              any_match;

    elgm_pkg::t_result awaited_results[$];
    int      failures;

    function new();
        home_zone   = '0;
        home_digits = '0;
        any_usable  = 1'b0;
        any_match   = 1'b0;
        failures    = 0;
        clear_code();
    endfunction

    function void clear_code();
        phase       = elgm_pkg::PH_Z;
        zone_val    = '0;
        zone_chars  = '0;
        digit_count = '0;
        prefix_ok   = 1'b1;
        sub_val     = '0;
        sub_chars   = '0;
        code_open   = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [4*NUM_DIGITS-1:0] data);
        if (idx == elgm_pkg::CFG_HOME_ZONE) begin
            home_zone = data[elgm_pkg::HOME_ZONE_W-1:0];
        end else begin
            home_digits = data;
        end
    endfunction

    function bit hex_value(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= elgm_pkg::CH_0 && c <= elgm_pkg::CH_9) begin
            v = 4'(c - elgm_pkg::CH_0);
            return 1'b1;
        end
        if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            v = 4'(c - CH_LOW_A + 8'd10);
            return 1'b1;
        end
        if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = 4'(c - CH_UP_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function logic [3:0] home_digit(int i);
        if (i >= NUM_DIGITS) return 4'd0;
        return home_digits[4*(NUM_DIGITS-1-i) +: 4];
    endfunction

    function void take_char(logic [7:0] c);
        logic [3:0] nib;
        bit         is_hex;
        is_hex = hex_value(c, nib);
        code_open = 1'b1;
        case (phase)
            elgm_pkg::PH_Z: begin
                phase = (c == elgm_pkg::CH_Z) ? elgm_pkg::PH_ZONE : elgm_pkg::PH_ERR;
            end
            elgm_pkg::PH_ZONE: begin
                if (c == elgm_pkg::CH_COLON) begin
                    phase = (zone_chars >= 1 && zone_chars <= elgm_pkg::ZONE_CHARS_MAX &&
                             zone_val <= elgm_pkg::ZONE_MAX) ? elgm_pkg::PH_DIG
                                                             : elgm_pkg::PH_ERR;
                end else if (c >= elgm_pkg::CH_0 && c <= elgm_pkg::CH_9 &&
                             zone_chars < elgm_pkg::ZONE_CHARS_MAX) begin
                    zone_val   = elgm_pkg::ZONE_W'(zone_val * 10 + (c - elgm_pkg::CH_0));
                    zone_chars = zone_chars + 3'd1;
                end else begin
                    phase = elgm_pkg::PH_ERR;
                end
            end
            elgm_pkg::PH_DIG: begin
                if (c == elgm_pkg::CH_PLUS) begin
                    phase = (digit_count >= 1) ? elgm_pkg::PH_SUB : elgm_pkg::PH_ERR;
                end else if (is_hex && digit_count < NUM_DIGITS) begin
                    if (nib != home_digit(digit_count)) prefix_ok = 1'b0;
                    digit_count = digit_count + 3'd1;
                end else begin
                    phase = elgm_pkg::PH_ERR;
                end
            end
            elgm_pkg::PH_SUB: begin
                if (is_hex && sub_chars < elgm_pkg::SUB_CHARS) begin
                    sub_val   = {sub_val[elgm_pkg::SUB_W-5:0], nib};
                    sub_chars = sub_chars + 3'd1;
                end else begin
                    phase = elgm_pkg::PH_ERR;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Verdict on the code being closed; also updates the list flags.
    function elgm_pkg::t_status predict_code_status();
        bit valid;
        bit hit;
        if (phase == elgm_pkg::PH_DIG) begin
            valid = digit_count >= 1;
        end else if (phase == elgm_pkg::PH_SUB) begin
            valid = digit_count >= 1 && sub_chars == elgm_pkg::SUB_CHARS;
        end else begin
            valid = 1'b0;
        end
        if (!valid) return elgm_pkg::ST_INVALID;
        any_usable = 1'b1;
        hit = (zone_val == home_zone) && prefix_ok;
        if (hit && phase == elgm_pkg::PH_SUB && digit_count < NUM_DIGITS) begin
            hit = sub_val[home_digit(digit_count)];
        end
        if (hit) any_match = 1'b1;
        return hit ? elgm_pkg::ST_MATCH : elgm_pkg::ST_NO_MATCH;
    endfunction

    function void take_transaction(logic [1:0] cmd, logic [7:0] ch);
        elgm_pkg::t_result r;
        r = '0;
        case (cmd)
            elgm_pkg::CMD_CHAR: begin
                take_char(ch);
            end
            elgm_pkg::CMD_END_CODE: begin
                r.code_closed = 1'b1;
                r.code_status = predict_code_status();
                clear_code();
                awaited_results.insert(awaited_results.size(), r);
            end
            elgm_pkg::CMD_END_LIST: begin
                r.code_closed = code_open;
                r.code_status = code_open ? predict_code_status() : elgm_pkg::ST_INVALID;
                r.list_done   = 1'b1;
                r.relevant    = any_match || !any_usable;
                clear_code();
                any_usable = 1'b0;
                any_match  = 1'b0;
                awaited_results.insert(awaited_results.size(), r);
            end
            default: begin
            end
        endcase
    endfunction

    function void check_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    function void compare_result(logic closed, logic [1:0] status, logic done, logic rel);
        elgm_pkg::t_result want;
        if (awaited_results.size() == 0) begin
            $error("result transaction arrived with no prediction waiting");
            failures++;
            return;
        end
        want = awaited_results.pop_front();
        check_field("code_closed", 2'(want.code_closed), 2'(closed));
        check_field("code_status", want.code_status, status);
        check_field("list_done", 2'(want.list_done), 2'(done));
        check_field("relevant", 2'(want.relevant), 2'(rel));
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

endclass

module testbench;

    localparam int         CFG_W         = 24;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    // Results leave the block after the closing transaction passes the input and result registers.
    localparam int         SETTLE_CYCLES = 4;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SEG_ITEMS     = 125;
    localparam int         NUM_SEGMENTS  = 9;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [1:0]       i_cmd;
    logic [7:0]       i_ch;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_code_closed;
    logic [1:0]       o_code_status;
    logic             o_list_done;
    logic             o_relevant;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [CFG_W-1:0] i_cfg_wdata;

    ews_location_code_geofence_match dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_ch          (i_ch),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_closed (o_code_closed),
        .o_code_status (o_code_status),
        .o_list_done   (o_list_done),
        .o_relevant    (o_relevant),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    geofence_tracker tracker = new();

    // Idle percentages for the two sides, set per stimulus phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req = 1'b0;
    // Transactions offered so far, not counting the ignored command.
    int items_sent = 0;
    // Copy of the home location used to build codes that tend to match.
    logic [5:0]       cur_zone = '0;
    logic [CFG_W-1:0] cur_digits = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every accepted transaction is fed to the tracker at the edge that
    // accepts it. Sampling happens in the active region of the edge, so all
    // values read here are the ones the block saw at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                tracker.write_reg(i_cfg_index, i_cfg_wdata);
            end
            if (i_in_valid && !o_in_stall) begin
                tracker.take_transaction(i_cmd, i_ch);
            end
            if (o_out_valid && !i_out_stall) begin
                tracker.compare_result(o_code_closed, o_code_status, o_list_done, o_relevant);
            end
        end
    end

    // Receiver. It stalls at random, and once on request it holds off for a
    // long stretch so that the result path fills and the input backs up.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: the run is dead if neither channel moves for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offers one transaction, with a random idle gap before it, and returns
    // after the edge that accepts it. Valid stays high into the next call,
    // so back-to-back transactions never see valid dropped and raised again.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_ch       <= ch;
        if (cmd != CMD_UNUSED) items_sent++;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_item(elgm_pkg::CMD_CHAR, s[k]);
        end
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return 8'(elgm_pkg::CH_0 + v);
        return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10);
    endfunction

    // Builds one location code, mostly near the home location, and sends
    // its characters. A broken code gets one random change to its characters.
    task automatic send_code(input bit broken);
        logic [7:0] chars[$];
        int         zone;
        int         nz;
        int         ndig;
        int         k;
        int         p;
        int         pos;
        logic [3:0] nib;
        case ($urandom_range(3))
            0, 1:    zone = cur_zone;
            default: zone = $urandom_range(elgm_pkg::ZONE_MAX);
        endcase
        chars.insert(chars.size(), elgm_pkg::CH_Z);
        nz = (zone >= 10) ? 2 : 1;
        if ($urandom_range(3) == 0) nz++;
        for (k = nz - 1; k >= 0; k--) begin
            p = (k == 2) ? 100 : (k == 1) ? 10 : 1;
            chars.insert(chars.size(), 8'(elgm_pkg::CH_0 + (zone / p) % 10));
        end
        chars.insert(chars.size(), elgm_pkg::CH_COLON);
        ndig = $urandom_range(1, 6);
        for (k = 0; k < ndig; k++) begin
            nib = ($urandom_range(99) < 85) ? cur_digits[4*(5-k) +: 4] : 4'($urandom);
            chars.insert(chars.size(), hex_char(nib));
        end
        if ($urandom_range(1)) begin
            chars.insert(chars.size(), elgm_pkg::CH_PLUS);
            repeat (elgm_pkg::SUB_CHARS) chars.insert(chars.size(), hex_char(4'($urandom)));
        end
        if (broken) begin
            pos = $urandom_range(chars.size() - 1);
            case ($urandom_range(5))
                0: chars[pos] = 8'($urandom);
                1: chars.insert(pos, 8'($urandom));
                2: chars.delete(pos);
                3: chars.insert(chars.size(), hex_char(4'($urandom)));
                4: chars.delete(chars.size() - 1);
                default: chars.insert(1, elgm_pkg::CH_0);
            endcase
        end
        for (k = 0; k < chars.size(); k++) begin
            send_item(elgm_pkg::CMD_CHAR, chars[k]);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 5)) send_item(elgm_pkg::CMD_CHAR, 8'($urandom));
    endtask

    // One alert list: a few codes of mixed quality, sometimes an empty code,
    // and sometimes the last code left open for the end-of-list transaction.
    task automatic send_list();
        int ncodes;
        int kind;
        int k;
        bit open_end;
        ncodes = $urandom_range(0, 4);
        for (k = 0; k < ncodes; k++) begin
            kind = $urandom_range(99);
            if (kind < 78) begin
                send_code(1'b0);
            end else if (kind < 90) begin
                send_code(1'b1);
            end else if (kind < 95) begin
                send_noise();
            end
            if ($urandom_range(19) == 0) send_item(CMD_UNUSED, 8'($urandom));
            open_end = (k == ncodes - 1) && ($urandom_range(1) == 1);
            if (!open_end) send_item(elgm_pkg::CMD_END_CODE, 8'($urandom));
        end
        send_item(elgm_pkg::CMD_END_LIST, 8'($urandom));
    endtask

    // Stops offering, waits for every predicted result, then lets the
    // pipeline drain any character still in flight. The first edge makes
    // sure the transaction accepted last has reached the tracker.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers on consecutive edges. Bits above the zone field
    // carry junk to show that only the low bits count.
    task automatic set_home(input logic [5:0] zone, input logic [CFG_W-1:0] digits);
        cur_zone   = zone;
        cur_digits = digits;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= elgm_pkg::CFG_HOME_ZONE;
        i_cfg_wdata <= {18'($urandom), zone};
        @(posedge i_clk);
        i_cfg_index <= elgm_pkg::CFG_HOME_DIGITS;
        i_cfg_wdata <= digits;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int seg;
        int target;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_cmd       <= elgm_pkg::CMD_CHAR;
        i_ch        <= 8'd0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= elgm_pkg::CFG_HOME_ZONE;
        i_cfg_wdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with home location Z7:1A2B3C.
        set_home(6'd7, 24'h1A2B3C);
        // An empty code is invalid; a bare end of list with nothing valid
        // seen is relevant; the unused command is dropped.
        send_item(elgm_pkg::CMD_END_CODE, 8'hFF);
        send_item(elgm_pkg::CMD_END_LIST, 8'h00);
        send_item(CMD_UNUSED, 8'hFF);
        // A one-digit prefix of the home digits matches.
        send_text("Z7:1");
        send_item(elgm_pkg::CMD_END_CODE, 8'h00);
        // A bad first character poisons the rest of the code.
        send_item(elgm_pkg::CMD_CHAR, 8'hFF);
        send_item(elgm_pkg::CMD_CHAR, 8'h00);
        send_item(elgm_pkg::CMD_END_CODE, 8'h00);
        // The next home digit is A, so subcode bit 10 decides; the code is
        // still open when the list ends.
        send_text("Z7:1+0400");
        send_item(elgm_pkg::CMD_END_LIST, 8'h00);

        // Random part in segments, each with its own home location.
        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            settle();
            case (seg)
                0: set_home(6'd0, 24'h000000);
                1: set_home(6'(elgm_pkg::ZONE_MAX), 24'hFFFFFF);
                2: set_home(6'd63, 24'($urandom));
                4: set_home(6'($urandom_range(elgm_pkg::ZONE_MAX + 1, 63)), 24'($urandom));
                default: set_home(6'($urandom_range(elgm_pkg::ZONE_MAX)), 24'($urandom));
            endcase
            if (seg < 3) begin
                send_idle_pct  = 9;
                recv_stall_pct = 66;
            end else if (seg < 6) begin
                send_idle_pct  = 66;
                recv_stall_pct = 9;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // With no sender gaps the long hold-off backs the block up.
            if (seg == 6) hold_req = 1'b1;
            target = items_sent + SEG_ITEMS;
            while (items_sent < target) send_list();
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
